// ----- rtl/core/fbgp_pkg.sv -----
// shared constants, types and helpers for the glyph plotter
`default_nettype none
package fbgp_pkg;

  localparam int DISPLAY_WIDTH   = 128;
  localparam int DISPLAY_HEIGHT  = 64;
  localparam int MAX_FONT_HEIGHT = 16;
  localparam int GLYPH_COUNT     = 95;

  localparam int PAGE_COUNT  = (DISPLAY_HEIGHT + 7) / 8;
  localparam int FRAME_BYTES = DISPLAY_WIDTH * PAGE_COUNT;
  localparam int GLYPH_ROWS  = GLYPH_COUNT * MAX_FONT_HEIGHT;
  localparam int FRAME_AW    = $clog2(FRAME_BYTES);
  localparam int GLYPH_AW    = $clog2(GLYPH_ROWS);
  localparam int FIRST_CODE  = 32;
  localparam int LAST_CODE   = 126;
  localparam int MAX_FONT_WIDTH = 16;

  // request kinds
  localparam logic [2:0] REQ_FILL   = 3'd0;
  localparam logic [2:0] REQ_PIXEL  = 3'd1;
  localparam logic [2:0] REQ_CURSOR = 3'd2;
  localparam logic [2:0] REQ_CHAR   = 3'd3;
  localparam logic [2:0] REQ_GLYPH  = 3'd4;
  localparam logic [2:0] REQ_READ   = 3'd5;

  // register indexes
  localparam logic [1:0] CFG_INVERT      = 2'd0;
  localparam logic [1:0] CFG_FONT_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_FONT_HEIGHT = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL,
    ST_RMW_RD,
    ST_RMW_WR,
    ST_RD_WAIT,
    ST_RD_DATA,
    ST_CH_GRD,
    ST_CH_GLD,
    ST_CH_PIX,
    ST_DONE
  } state_t;

  // byte address of pixel (x, y) in the paged layout
  function automatic logic [FRAME_AW-1:0] frame_index(input logic [7:0] x,
                                                      input logic [7:0] y);
    int page;
    page = int'(y >> 3);
    return FRAME_AW'(int'(x) + page * DISPLAY_WIDTH);
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/framebuffer_glyph_plotter.sv -----
// top level: paged monochrome frame buffer with pixel, fill, text and glyph requests
`default_nettype none
// One result word per request word. Frame buffer and glyph rows live in two
// single-port-write synchronous memories; pixel and character drawing is
// read-modify-write on the frame memory, one pixel at a time, while fill writes
// whole bytes. After reset the block sweeps all FRAME_BYTES bytes (1024 at
// 128x64) of the frame memory to zero with s_tready low; configuration writes
// are taken during that time. A character costs the frame memory one
// read-modify-write per set glyph bit. A new request word is taken while the
// previous result still waits on the master side.
module framebuffer_glyph_plotter (
  input  wire logic        clk,
  input  wire logic        rst,
  // request channel
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // pos_x[7:0] pos_y[15:8] colour[16] char_code[24:17] glyph_row_bits[40:25]
  // glyph_row_index[51:41] byte_index[61:52], zero pad above
  input  wire logic [63:0] s_tdata,
  // req_type[2:0]
  input  wire logic [2:0]  s_tuser,
  // result channel
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // accepted[0] read_byte[8:1] cursor_col[16:9] cursor_row[24:17], zero pad above
  output logic [31:0]      m_tdata,
  // configuration writes
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [4:0]  cfg_data
);

  // request word fields
  logic [2:0]  req_type;
  logic [7:0]  pos_x;
  logic [7:0]  pos_y;
  logic        colour;
  logic [7:0]  char_code;
  logic [15:0] glyph_row_bits;
  logic [10:0] glyph_row_index;
  logic [9:0]  byte_index;

  assign req_type        = s_tuser;
  assign pos_x           = s_tdata[7:0];
  assign pos_y           = s_tdata[15:8];
  assign colour          = s_tdata[16];
  assign char_code       = s_tdata[24:17];
  assign glyph_row_bits  = s_tdata[40:25];
  assign glyph_row_index = s_tdata[51:41];
  assign byte_index      = s_tdata[61:52];

  // configuration registers
  logic       invert_colour;
  logic [4:0] font_width;
  logic [4:0] font_height;

  // text cursor
  logic [7:0] text_col;
  logic [7:0] text_row;

  fbgp_pkg::state_t state, state_next, ret_state;

  // sweep counter for reset clear and fill
  logic [fbgp_pkg::FRAME_AW-1:0] sweep_cnt;
  logic                          sweep_last;
  logic [7:0]                    fill_byte;

  // pixel read-modify-write operands
  logic [fbgp_pkg::FRAME_AW-1:0] px_idx;
  logic [2:0]                    px_bit;
  logic                          px_set;
  logic [7:0]                    px_mask;
  logic [7:0]                    px_byte;

  // character walk
  logic [12:0] ch_base;
  logic [12:0] ch_addr;
  logic        ch_addr_ok;
  logic [3:0]  ch_r;
  logic [3:0]  ch_c;
  logic [15:0] ch_bits;
  logic        ch_set;
  logic [7:0]  ch_col;
  logic [7:0]  ch_row;
  logic        col_last;
  logic        row_last;
  fbgp_pkg::state_t ch_step_state;
  logic [7:0]  ch_px_x;
  logic [7:0]  ch_px_y;

  // result staging
  logic       res_acc;
  logic [7:0] res_byte;
  logic       out_free;

  // request checks
  logic pix_ok;
  logic char_ok;
  logic gl_ok;
  logic rd_ok;
  logic [7:0]  code_off;
  logic [12:0] base_calc;

  // memory ports
  logic                          fb_we;
  logic [fbgp_pkg::FRAME_AW-1:0] fb_waddr;
  logic [7:0]                    fb_wdata;
  logic [7:0]                    fb_rdata;
  logic                          gl_we;
  logic [fbgp_pkg::GLYPH_AW-1:0] gl_raddr;
  logic [15:0]                   gl_rdata;

  logic [7:0]  frame_mem [0:fbgp_pkg::FRAME_BYTES-1];
  logic [15:0] glyph_mem [0:fbgp_pkg::GLYPH_ROWS-1];

  assign out_free   = !m_tvalid || m_tready;
  assign sweep_last = sweep_cnt == fbgp_pkg::FRAME_AW'(fbgp_pkg::FRAME_BYTES - 1);

  assign pix_ok = int'(pos_x) < fbgp_pkg::DISPLAY_WIDTH &&
                  int'(pos_y) < fbgp_pkg::DISPLAY_HEIGHT;
  assign gl_ok  = int'(glyph_row_index) < fbgp_pkg::GLYPH_ROWS;
  assign rd_ok  = int'(byte_index) < fbgp_pkg::FRAME_BYTES;

  // printable code within the glyph store, sane font size, and the glyph fits
  assign char_ok = int'(char_code) >= fbgp_pkg::FIRST_CODE &&
                   int'(char_code) <= fbgp_pkg::LAST_CODE &&
                   int'(char_code) - fbgp_pkg::FIRST_CODE < fbgp_pkg::GLYPH_COUNT &&
                   font_width != 5'd0 &&
                   int'(font_width) <= fbgp_pkg::MAX_FONT_WIDTH &&
                   font_height != 5'd0 &&
                   int'(font_height) <= fbgp_pkg::MAX_FONT_HEIGHT &&
                   int'(text_col) + int'(font_width) < fbgp_pkg::DISPLAY_WIDTH &&
                   int'(text_row) + int'(font_height) < fbgp_pkg::DISPLAY_HEIGHT;

  assign code_off  = char_code - 8'(fbgp_pkg::FIRST_CODE);
  assign base_calc = 13'(code_off) * 13'(font_height);

  // glyph row address for the current row; rows beyond the store read as blank
  assign ch_addr    = ch_base + 13'(ch_r);
  assign ch_addr_ok = int'(ch_addr) < fbgp_pkg::GLYPH_ROWS;
  assign gl_raddr   = fbgp_pkg::GLYPH_AW'(ch_addr);

  assign col_last = (5'(ch_c) + 5'd1) == font_width;
  assign row_last = (5'(ch_r) + 5'd1) == font_height;
  assign ch_px_x  = ch_col + 8'(ch_c);
  assign ch_px_y  = ch_row + 8'(ch_r);

  always_comb begin
    if (!col_last) begin
      ch_step_state = fbgp_pkg::ST_CH_PIX;
    end else if (row_last) begin
      ch_step_state = fbgp_pkg::ST_DONE;
    end else begin
      ch_step_state = fbgp_pkg::ST_CH_GRD;
    end
  end

  // modified byte for the pixel write
  assign px_mask = 8'd1 << px_bit;
  assign px_byte = px_set ? (fb_rdata | px_mask) : (fb_rdata & ~px_mask);

  // frame memory: read address is always the pixel/byte operand
  always_ff @(posedge clk) begin
    if (fb_we) begin
      frame_mem[fb_waddr] <= fb_wdata;
    end
    fb_rdata <= frame_mem[px_idx];
  end

  // glyph memory: written straight from the request word
  always_ff @(posedge clk) begin
    if (gl_we) begin
      glyph_mem[fbgp_pkg::GLYPH_AW'(glyph_row_index)] <= glyph_row_bits;
    end
    gl_rdata <= glyph_mem[gl_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fbgp_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and memory strobes
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    fb_we      = 1'b0;
    fb_waddr   = sweep_cnt;
    fb_wdata   = fill_byte;
    gl_we      = 1'b0;
    case (state)
      fbgp_pkg::ST_CLEAR: begin
        fb_we    = 1'b1;
        fb_wdata = 8'h00;
        if (sweep_last) begin
          state_next = fbgp_pkg::ST_IDLE;
        end
      end
      fbgp_pkg::ST_FILL: begin
        fb_we = 1'b1;
        if (sweep_last) begin
          state_next = fbgp_pkg::ST_DONE;
        end
      end
      fbgp_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          case (req_type)
            fbgp_pkg::REQ_FILL:   state_next = fbgp_pkg::ST_FILL;
            fbgp_pkg::REQ_PIXEL:
              state_next = pix_ok ? fbgp_pkg::ST_RMW_RD : fbgp_pkg::ST_DONE;
            fbgp_pkg::REQ_CHAR:
              state_next = char_ok ? fbgp_pkg::ST_CH_GRD : fbgp_pkg::ST_DONE;
            fbgp_pkg::REQ_GLYPH: begin
              gl_we      = gl_ok;
              state_next = fbgp_pkg::ST_DONE;
            end
            fbgp_pkg::REQ_READ:
              state_next = rd_ok ? fbgp_pkg::ST_RD_WAIT : fbgp_pkg::ST_DONE;
            default:              state_next = fbgp_pkg::ST_DONE;
          endcase
        end
      end
      fbgp_pkg::ST_RMW_RD:  state_next = fbgp_pkg::ST_RMW_WR;
      fbgp_pkg::ST_RMW_WR: begin
        fb_we      = 1'b1;
        fb_waddr   = px_idx;
        fb_wdata   = px_byte;
        state_next = ret_state;
      end
      fbgp_pkg::ST_RD_WAIT: state_next = fbgp_pkg::ST_RD_DATA;
      fbgp_pkg::ST_RD_DATA: state_next = fbgp_pkg::ST_DONE;
      fbgp_pkg::ST_CH_GRD:  state_next = fbgp_pkg::ST_CH_GLD;
      fbgp_pkg::ST_CH_GLD:  state_next = fbgp_pkg::ST_CH_PIX;
      fbgp_pkg::ST_CH_PIX: begin
        // set bits take a read-modify-write detour, clear bits step on
        state_next = ch_bits[15] ? fbgp_pkg::ST_RMW_RD : ch_step_state;
      end
      fbgp_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = fbgp_pkg::ST_IDLE;
        end
      end
      default: state_next = fbgp_pkg::ST_IDLE;
    endcase
  end

  // control registers, cursor and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      invert_colour <= 1'b0;
      font_width    <= 5'd7;
      font_height   <= 5'd10;
      text_col      <= 8'd0;
      text_row      <= 8'd0;
      sweep_cnt     <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          fbgp_pkg::CFG_INVERT:      invert_colour <= cfg_data[0];
          fbgp_pkg::CFG_FONT_WIDTH:  font_width    <= cfg_data;
          fbgp_pkg::CFG_FONT_HEIGHT: font_height   <= cfg_data;
          default: ;
        endcase
      end
      // result word goes out from the done state, drops once taken
      if (state == fbgp_pkg::ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        fbgp_pkg::ST_CLEAR, fbgp_pkg::ST_FILL: begin
          sweep_cnt <= sweep_cnt + 1'b1;
        end
        fbgp_pkg::ST_IDLE: begin
          sweep_cnt <= '0;
          if (s_tvalid && req_type == fbgp_pkg::REQ_CURSOR) begin
            text_col <= pos_x;
            text_row <= pos_y;
          end
        end
        fbgp_pkg::ST_CH_PIX: begin
          // cursor advances once the last glyph pixel has been walked
          if (col_last && row_last) begin
            text_col <= ch_col + 8'(font_width);
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (state)
      fbgp_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          res_byte <= 8'd0;
          case (req_type)
            fbgp_pkg::REQ_FILL: begin
              fill_byte <= colour ? 8'hFF : 8'h00;
              res_acc   <= 1'b1;
            end
            fbgp_pkg::REQ_PIXEL: begin
              px_idx    <= fbgp_pkg::frame_index(pos_x, pos_y);
              px_bit    <= pos_y[2:0];
              px_set    <= colour ^ invert_colour;
              ret_state <= fbgp_pkg::ST_DONE;
              res_acc   <= pix_ok;
            end
            fbgp_pkg::REQ_CURSOR: res_acc <= 1'b1;
            fbgp_pkg::REQ_CHAR: begin
              ch_base <= base_calc;
              ch_r    <= 4'd0;
              ch_c    <= 4'd0;
              ch_set  <= colour ^ invert_colour;
              ch_col  <= text_col;
              ch_row  <= text_row;
              res_acc <= 1'b0;
            end
            fbgp_pkg::REQ_GLYPH:  res_acc <= gl_ok;
            fbgp_pkg::REQ_READ: begin
              px_idx  <= fbgp_pkg::FRAME_AW'(byte_index);
              res_acc <= rd_ok;
            end
            default: res_acc <= 1'b0;
          endcase
        end
      end
      fbgp_pkg::ST_RD_DATA: res_byte <= fb_rdata;
      fbgp_pkg::ST_CH_GLD: begin
        ch_bits <= ch_addr_ok ? gl_rdata : 16'd0;
        ch_c    <= 4'd0;
      end
      fbgp_pkg::ST_CH_PIX: begin
        ch_bits <= ch_bits << 1;
        if (ch_bits[15]) begin
          px_idx    <= fbgp_pkg::frame_index(ch_px_x, ch_px_y);
          px_bit    <= ch_px_y[2:0];
          px_set    <= ch_set;
          ret_state <= ch_step_state;
        end
        if (col_last) begin
          ch_r <= ch_r + 4'd1;
          if (row_last) begin
            res_acc <= 1'b1;
          end
        end else begin
          ch_c <= ch_c + 4'd1;
        end
      end
      fbgp_pkg::ST_DONE: begin
        if (out_free) begin
          m_tdata <= {7'd0, text_row, text_col, res_byte, res_acc};
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ----- test/fbgp_reply_checker.sv -----
// result checker for the glyph plotter: mirrors buffer, glyph rows, cursor and registers
`timescale 1ns / 100ps
module fbgp_reply_checker
  import fbgp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [63:0] s_tdata,
  input  logic [2:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data,
  output int          error_count,
  output int          replies_seen,
  output int          due_count,
  output int          chars_drawn
);

  typedef struct packed {
    logic       accepted;
    logic [7:0] read_byte;
    logic [7:0] cursor_col;
    logic [7:0] cursor_row;
  } reply_t;

  logic [7:0]  frame_mirror [FRAME_BYTES];
  logic [15:0] glyph_mirror [GLYPH_ROWS];
  logic [7:0]  text_col;
  logic [7:0]  text_row;
  logic        invert_on;
  logic [4:0]  font_w;
  logic [4:0]  font_h;
  reply_t      due_replies [$];

  initial begin
    error_count = 0;
    replies_seen = 0;
    due_count = 0;
    chars_drawn = 0;
  end

  task automatic report_mismatch(string what, int got, int want);
    error_count++;
    if (error_count <= 30)
      $display("[%0t] result mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  function automatic logic plot_pixel(int x, int y, logic colour);
    int idx;
    if (x >= DISPLAY_WIDTH || y >= DISPLAY_HEIGHT) return 1'b0;
    idx = x + (y / 8) * DISPLAY_WIDTH;
    frame_mirror[idx][y % 8] = colour ^ invert_on;
    return 1'b1;
  endfunction

  function automatic logic draw_char(int code, logic colour);
    int col;
    int row;
    int base;
    logic [15:0] bits;
    col = text_col;
    row = text_row;
    if (code < FIRST_CODE || code > LAST_CODE || code - FIRST_CODE >= GLYPH_COUNT) return 1'b0;
    if (font_w < 1 || font_w > MAX_FONT_WIDTH) return 1'b0;
    if (font_h < 1 || font_h > MAX_FONT_HEIGHT) return 1'b0;
    if (col + font_w >= DISPLAY_WIDTH || row + font_h >= DISPLAY_HEIGHT) return 1'b0;
    base = (code - FIRST_CODE) * font_h;
    for (int r = 0; r < font_h; r++) begin
      bits = glyph_mirror[base + r];
      for (int c = 0; c < font_w; c++)
        if (bits[15 - c]) void'(plot_pixel(col + c, row + r, colour));
    end
    text_col = 8'(col + font_w);
    return 1'b1;
  endfunction

  // carries out one request on the mirror and returns the result word it must produce
  function automatic reply_t apply_request(logic [2:0] kind, logic [63:0] word);
    reply_t r;
    r = '0;
    case (kind)
      REQ_FILL: begin
        foreach (frame_mirror[i]) frame_mirror[i] = {8{word[16]}};
        r.accepted = 1'b1;
      end
      REQ_PIXEL: r.accepted = plot_pixel(word[7:0], word[15:8], word[16]);
      REQ_CURSOR: begin
        text_col = word[7:0];
        text_row = word[15:8];
        r.accepted = 1'b1;
      end
      REQ_CHAR: r.accepted = draw_char(word[24:17], word[16]);
      REQ_GLYPH: begin
        if (word[51:41] < GLYPH_ROWS) begin
          glyph_mirror[word[51:41]] = word[40:25];
          r.accepted = 1'b1;
        end
      end
      REQ_READ: begin
        if (word[61:52] < FRAME_BYTES) begin
          r.read_byte = frame_mirror[word[61:52]];
          r.accepted = 1'b1;
        end
      end
      default: ;
    endcase
    r.cursor_col = text_col;
    r.cursor_row = text_row;
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      foreach (frame_mirror[i]) frame_mirror[i] = 8'h00;
      text_col = 8'd0;
      text_row = 8'd0;
      invert_on = 1'b0;
      font_w = 5'd7;
      font_h = 5'd10;
      due_replies.delete();
    end else begin
      // results first: a result never belongs to a request taken at the same edge
      if (m_tvalid && m_tready) begin
        if (due_replies.size() == 0) begin
          report_mismatch("unrequested result word", m_tdata, 0);
        end else begin
          want = due_replies.pop_front();
          if (m_tdata[0] !== want.accepted)
            report_mismatch("accepted", m_tdata[0], want.accepted);
          if (m_tdata[8:1] !== want.read_byte)
            report_mismatch("read_byte", m_tdata[8:1], want.read_byte);
          if (m_tdata[16:9] !== want.cursor_col)
            report_mismatch("cursor_col", m_tdata[16:9], want.cursor_col);
          if (m_tdata[24:17] !== want.cursor_row)
            report_mismatch("cursor_row", m_tdata[24:17], want.cursor_row);
        end
        replies_seen <= replies_seen + 1;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_INVERT:      invert_on = cfg_data[0];
          CFG_FONT_WIDTH:  font_w = cfg_data;
          CFG_FONT_HEIGHT: font_h = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        want = apply_request(s_tuser, s_tdata);
        due_replies.push_back(want);
        if (s_tuser == REQ_CHAR && want.accepted) chars_drawn++;
      end
    end
    due_count <= due_replies.size();
  end

endmodule

// ----- test/tb.sv -----
// testbench top for the glyph plotter: request stimulus, stall patterns and verdict
`timescale 1ns / 100ps
module tb;
  import fbgp_pkg::*;

  localparam int LIMIT_CYCLES  = 2_500_000;
  localparam int HOLD_CYCLES   = 1500;
  localparam int SETTLE_CYCLES = 40;
  localparam int ROW_INDEX_MAX = 2047;  // top of the 11-bit glyph address field

  // request kinds the block does not know
  localparam logic [2:0] REQ_UNKNOWN_LO = 3'd6;
  localparam logic [2:0] REQ_UNKNOWN_HI = 3'd7;

  // request word layout, lowest bit last
  typedef struct packed {
    logic [1:0]  pad;
    logic [9:0]  byte_index;
    logic [10:0] row_index;
    logic [15:0] row_bits;
    logic [7:0]  char_code;
    logic        colour;
    logic [7:0]  pos_y;
    logic [7:0]  pos_x;
  } plot_fields_t;

  typedef struct {
    logic [2:0]   kind;
    plot_fields_t fields;
  } plot_req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [4:0]  cfg_data = '0;

  int error_count;
  int replies_seen;
  int due_count;
  int chars_drawn;

  // stimulus bookkeeping
  plot_req_t req_q [$];
  int  pushed_total = 0;   // every word queued, unknown kinds included
  int  item_total = 0;     // words the block acts on
  int  phase_total = 0;
  int  cycle_count = 0;
  bit  glyph_written [GLYPH_ROWS];
  int  cur_fw = 7;
  int  cur_fh = 10;
  int  palette [4];

  // handshake pacing
  logic hold_off = 1'b0;
  bit   pressure_go = 1'b0;
  int   burst_left = 0;
  int   gap_left = 0;
  int   ready_left = 0;
  logic ready_phase = 1'b1;

  always #2 clk = ~clk;

  framebuffer_glyph_plotter dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  fbgp_reply_checker reply_check (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .error_count (error_count),
    .replies_seen(replies_seen),
    .due_count   (due_count),
    .chars_drawn (chars_drawn)
  );

  // sender: bursts of random length, random gaps between them, word held until taken
  always @(posedge clk) begin
    plot_req_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (gap_left > 0 || req_q.size() == 0) begin
        if (gap_left > 0) gap_left--;
        s_tvalid <= 1'b0;
      end else begin
        nxt = req_q.pop_front();
        s_tvalid <= 1'b1;
        s_tuser <= nxt.kind;
        s_tdata <= nxt.fields;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 30);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end
  end

  // receiver: alternating ready and stall stretches, forced low during the hold-off
  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_phase = ~ready_phase;
      ready_left = ready_phase ? $urandom_range(1, 48) : $urandom_range(1, 6);
    end
    ready_left--;
    m_tready <= ready_phase && !hold_off;
  end

  // long receiver hold-off so the block fills and stalls its request side
  initial begin
    wait (pressure_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles: %0d of %0d results seen", cycle_count, replies_seen,
               pushed_total);
      $display("[framebuffer_glyph_plotter] ERROR");
      $finish;
    end
  end

  // unused fields carry random bits, the block must ignore them
  function automatic plot_fields_t random_fields();
    plot_fields_t f;
    f = {$urandom, $urandom};
    f.pad = 2'b00;
    return f;
  endfunction

  function automatic logic [15:0] glyph_pattern();
    case ($urandom_range(0, 7))
      0: return 16'hFFFF;
      1: return 16'h8001;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_word(logic [2:0] kind, plot_fields_t f);
    plot_req_t r;
    r.kind = kind;
    r.fields = f;
    if (kind == REQ_GLYPH && f.row_index < GLYPH_ROWS) glyph_written[f.row_index] = 1'b1;
    req_q.push_back(r);
    pushed_total++;
    if (kind <= REQ_READ) item_total++;
  endtask

  task automatic send_fill(int colour);
    plot_fields_t f;
    f = random_fields();
    f.colour = colour[0];
    queue_word(REQ_FILL, f);
  endtask

  task automatic send_pixel(int x, int y, int colour);
    plot_fields_t f;
    f = random_fields();
    f.pos_x = 8'(x);
    f.pos_y = 8'(y);
    f.colour = colour[0];
    queue_word(REQ_PIXEL, f);
  endtask

  task automatic send_cursor(int x, int y);
    plot_fields_t f;
    f = random_fields();
    f.pos_x = 8'(x);
    f.pos_y = 8'(y);
    queue_word(REQ_CURSOR, f);
  endtask

  task automatic send_glyph(int idx, logic [15:0] bits);
    plot_fields_t f;
    f = random_fields();
    f.row_index = 11'(idx);
    f.row_bits = bits;
    queue_word(REQ_GLYPH, f);
  endtask

  task automatic send_read(int idx);
    plot_fields_t f;
    f = random_fields();
    f.byte_index = 10'(idx);
    queue_word(REQ_READ, f);
  endtask

  task automatic send_unknown(logic [2:0] kind);
    queue_word(kind, random_fields());
  endtask

  // a character may only be drawn once all of its rows have been loaded
  task automatic ensure_glyph(int code);
    int addr;
    if (code < FIRST_CODE || code > LAST_CODE) return;
    if (cur_fh < 1 || cur_fh > MAX_FONT_HEIGHT) return;
    for (int r = 0; r < cur_fh; r++) begin
      addr = (code - FIRST_CODE) * cur_fh + r;
      if (!glyph_written[addr]) send_glyph(addr, glyph_pattern());
    end
  endtask

  task automatic send_char(int code, int colour);
    plot_fields_t f;
    ensure_glyph(code);
    f = random_fields();
    f.char_code = 8'(code);
    f.colour = colour[0];
    queue_word(REQ_CHAR, f);
  endtask

  // wait until every queued word has come back as a result, then let the block settle
  task automatic drain();
    while (replies_seen != pushed_total) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] index, int value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= 5'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // registers change only once every queued word has come back as a result
  task automatic start_phase(int invert, int fw, int fh);
    drain();
    cfg_write(CFG_INVERT, invert);
    cfg_write(CFG_FONT_WIDTH, fw);
    cfg_write(CFG_FONT_HEIGHT, fh);
    cur_fw = fw;
    cur_fh = fh;
    phase_total++;
    foreach (palette[i]) palette[i] = $urandom_range(FIRST_CODE, LAST_CODE);
  endtask

  // well-formed text: place the cursor where a glyph fits, draw a run, read back under it
  task automatic text_run();
    int col;
    int row;
    int runs;
    int code;
    int x;
    int y;
    col = $urandom_range(0, DISPLAY_WIDTH - 1 - cur_fw);
    row = $urandom_range(0, (cur_fh < DISPLAY_HEIGHT - 1) ? DISPLAY_HEIGHT - 1 - cur_fh : 0);
    send_cursor(col, row);
    runs = $urandom_range(1, 6);
    repeat (runs) begin
      if ($urandom_range(0, 7) == 0) code = $urandom_range(0, 255);
      else if ($urandom_range(0, 2) == 0) code = $urandom_range(FIRST_CODE, LAST_CODE);
      else code = palette[$urandom_range(0, 3)];
      send_char(code, $urandom_range(0, 1));
    end
    repeat ($urandom_range(1, 3)) begin
      x = col + $urandom_range(0, runs * cur_fw);
      y = row + $urandom_range(0, cur_fh);
      if (x > DISPLAY_WIDTH - 1) x = DISPLAY_WIDTH - 1;
      if (y > DISPLAY_HEIGHT - 1) y = DISPLAY_HEIGHT - 1;
      send_read(x + (y / 8) * DISPLAY_WIDTH);
    end
  endtask

  task automatic random_traffic();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      text_run();
    end else if (pick < 70) begin
      if ($urandom_range(0, 3) == 0)
        send_pixel($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 1));
      else
        send_pixel($urandom_range(0, DISPLAY_WIDTH - 1), $urandom_range(0, DISPLAY_HEIGHT - 1),
                   $urandom_range(0, 1));
    end else if (pick < 80) begin
      send_read($urandom_range(0, FRAME_BYTES - 1));
    end else if (pick < 87) begin
      send_glyph($urandom_range(0, ROW_INDEX_MAX), 16'($urandom));
    end else if (pick < 91) begin
      send_cursor($urandom_range(0, 255), $urandom_range(0, 255));
    end else if (pick < 96) begin
      send_char($urandom_range(0, 255), $urandom_range(0, 1));
    end else if (pick < 98) begin
      send_fill($urandom_range(0, 1));
    end else begin
      send_unknown($urandom_range(0, 1) ? REQ_UNKNOWN_HI : REQ_UNKNOWN_LO);
    end
  endtask

  task automatic run_random(int count);
    int target;
    target = item_total + count;
    while (item_total < target) random_traffic();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // registers go in while the block is still clearing its buffer
    start_phase(0, 7, 2);

    // fills, corner pixels, off-screen pixels
    send_fill(1);
    send_read(0);
    send_fill(0);
    send_pixel(0, 0, 1);
    send_pixel(DISPLAY_WIDTH - 1, DISPLAY_HEIGHT - 1, 1);
    send_pixel(DISPLAY_WIDTH, 0, 1);
    send_pixel(0, DISPLAY_HEIGHT, 1);
    send_pixel(255, 255, 1);
    send_read(0);
    send_read(FRAME_BYTES - 1);
    send_pixel(0, 0, 0);
    send_read(0);
    // cursor far outside, then glyphs just inside and just at the edges
    send_cursor(255, 255);
    send_char(LAST_CODE, 1);
    send_cursor(DISPLAY_WIDTH - 1 - cur_fw, DISPLAY_HEIGHT - 1 - cur_fh);
    send_char(LAST_CODE, 1);
    send_char(LAST_CODE, 1);
    send_cursor(DISPLAY_WIDTH - cur_fw, 0);
    send_char(FIRST_CODE, 1);
    send_cursor(0, DISPLAY_HEIGHT - cur_fh);
    send_char(FIRST_CODE, 1);
    // codes outside the printable range
    send_cursor(0, 0);
    send_char(FIRST_CODE - 1, 1);
    send_char(LAST_CODE + 1, 1);
    send_char(255, 1);
    send_char(FIRST_CODE, 1);
    send_read(0);
    // glyph store boundary and unknown kinds
    send_glyph(GLYPH_ROWS - 1, 16'hFFFF);
    send_glyph(GLYPH_ROWS, 16'h5A5A);
    send_glyph(ROW_INDEX_MAX, 16'hA5A5);
    send_unknown(REQ_UNKNOWN_LO);
    send_unknown(REQ_UNKNOWN_HI);
    run_random(50);

    start_phase(1, 1, 1);
    run_random(60);
    start_phase(0, MAX_FONT_WIDTH, MAX_FONT_HEIGHT);
    run_random(40);
    start_phase(1, 5, 8);
    run_random(90);
    // font sizes out of range: every character refused
    start_phase(0, 0, MAX_FONT_HEIGHT + 1);
    run_random(20);
    start_phase(0, 8, 12);
    run_random(90);

    // back-pressure: receiver holds off while the sender keeps offering
    start_phase(1, 3, 6);
    pressure_go = 1'b1;
    repeat (40) begin
      case ($urandom_range(0, 2))
        0: send_cursor($urandom_range(0, 255), $urandom_range(0, 255));
        1: send_glyph($urandom_range(0, GLYPH_ROWS - 1), 16'($urandom));
        default: send_read($urandom_range(0, FRAME_BYTES - 1));
      endcase
    end
    run_random(100);

    drain();
    $display("covered %0d request words over %0d register settings, %0d characters drawn",
             pushed_total, phase_total, chars_drawn);
    $display("receiver held off for %0d cycles once, %0d mismatches", HOLD_CYCLES, error_count);
    if (error_count == 0 && due_count == 0) begin
      $display("[framebuffer_glyph_plotter] OK");
    end else begin
      $display("[framebuffer_glyph_plotter] ERROR");
    end
    $finish;
  end

endmodule
